// ===== hdl/sensor_minmax_calibrate_normalize_defines.svh =====
// Assertion macros for the sensor min/max calibrate and normalize block.
`ifndef SENSOR_MINMAX_CALIBRATE_NORMALIZE_DEFINES_SVH
`define SENSOR_MINMAX_CALIBRATE_NORMALIZE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SMCN_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define SMCN_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/smcn_pkg.sv =====
// Shared types, constants and the channel map of the sensor normalize block.
package smcn_pkg;

	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W = 12;
	localparam int SLOT_W = 3;
	localparam int QUO_BITS = 12;
	localparam logic [LEVEL_W-1:0] FULL_SCALE = 12'd2560;
	localparam logic [3:0] NO_SLOT = 4'd15;
	localparam logic CMD_CALIBRATE = 1'b0;
	localparam logic CMD_NORMALIZE = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [SLOT_W-1:0] slot;
		logic [SAMPLE_W-1:0] sample;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} back_state_t;

	function automatic logic [3:0] chan_to_slot(input logic [2:0] chan);
		logic [3:0] slot;
		case (chan)
			3'd0: slot = 4'd4;
			3'd3: slot = 4'd2;
			3'd4: slot = 4'd3;
			3'd5: slot = 4'd5;
			3'd6: slot = 4'd0;
			3'd7: slot = 4'd1;
			default: slot = NO_SLOT;
		endcase
		return slot;
	endfunction

endpackage

// ===== hdl/smcn_front.sv =====
// Front end: accepts tagged samples, maps channels to slots, drops unmapped ones.
module smcn_front #(
	parameter int NUM_SLOTS = 6
) (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // adc_channel[2:0], sample[14:3], zero[15]
	input  logic              s_tuser,   // cmd[0]
	output logic              q_valid,
	input  logic              q_ready,
	output smcn_pkg::entry_t  q_data
);
	import smcn_pkg::*;

	logic [3:0] slot4;
	logic       mapped;

	assign slot4    = chan_to_slot(s_tdata[2:0]);
	assign mapped   = (slot4 < 4'(NUM_SLOTS));
	assign s_tready = q_ready;
	assign q_valid  = s_tvalid && mapped;

	always_comb begin
		q_data.cmd    = s_tuser;
		q_data.slot   = slot4[SLOT_W-1:0];
		q_data.sample = s_tdata[14:3];
	end

endmodule

// ===== hdl/smcn_queue.sv =====
// Two-entry queue between the front end and the back end.
module smcn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  smcn_pkg::entry_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output smcn_pkg::entry_t  out_data
);
	import smcn_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/smcn_back.sv =====
// Back end: slot min/max store, calibrate update, iterative divide, result register.
module smcn_back #(
	parameter int NUM_SLOTS = 6,
	parameter int SAMPLE_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              invert,
	input  logic              q_valid,
	output logic              q_ready,
	input  smcn_pkg::entry_t  q_data,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // slot[2:0], level[14:3], zero[15]
	output logic [1:0]        m_tuser    // clipped[0], uncalibrated[1]
);
	import smcn_pkg::*;

	localparam int W = SAMPLE_BITS;
	localparam int REM_W = W + QUO_BITS;
	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [W-1:0] MIN_RESET = {W{1'b1}};

	back_state_t state_q, state_d;

	logic [W-1:0]        min_q [NUM_SLOTS];
	logic [W-1:0]        max_q [NUM_SLOTS];
	entry_t              e_q;
	logic [REM_W-1:0]    rem_q;
	logic [REM_W-1:0]    dsh_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [3:0]          cnt_q;
	logic                clip_q;
	logic                uncal_q;

	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [LEVEL_W-1:0]  out_level_q;
	logic                out_clip_q;
	logic                out_uncal_q;

	logic                ld_entry;
	logic                upd_cal;
	logic                ld_div;
	logic                ld_uncal;
	logic                step;
	logic                ld_out;

	logic [IDX_W-1:0]    idx;
	logic [15:0]         s16;
	logic [W-1:0]        s_w;
	logic [W-1:0]        lo;
	logic [W-1:0]        hi;
	logic                calibrated;
	logic [W-1:0]        sc;
	logic                clip_d;
	logic [W-1:0]        diff;
	logic [W+3:0]        ten_d;
	logic [W-1:0]        span;
	logic                ge;
	logic [LEVEL_W-1:0]  level_d;

	assign idx        = e_q.slot[IDX_W-1:0];
	assign s16        = {4'b0, e_q.sample};
	assign s_w        = s16[W-1:0];
	assign lo         = min_q[idx];
	assign hi         = max_q[idx];
	assign calibrated = (hi > lo);

	always_comb begin
		sc     = s_w;
		clip_d = 1'b0;
		if (s_w < lo) begin
			sc     = lo;
			clip_d = 1'b1;
		end else if (s_w > hi) begin
			sc     = hi;
			clip_d = 1'b1;
		end
	end

	assign diff  = sc - lo;
	assign ten_d = ({4'b0, diff} << 3) + ({4'b0, diff} << 1);
	assign span  = hi - lo;
	assign ge    = (rem_q >= dsh_q);

	always_comb begin
		if (uncal_q) begin
			level_d = '0;
		end else if (invert) begin
			level_d = FULL_SCALE - quo_q;
		end else begin
			level_d = quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_ready  = 1'b0;
		ld_entry = 1'b0;
		upd_cal  = 1'b0;
		ld_div   = 1'b0;
		ld_uncal = 1'b0;
		step     = 1'b0;
		ld_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					ld_entry = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (e_q.cmd == CMD_CALIBRATE) begin
					upd_cal = 1'b1;
					state_d = ST_IDLE;
				end else if (!calibrated) begin
					ld_uncal = 1'b1;
					state_d  = ST_OUT;
				end else begin
					ld_div  = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				step = 1'b1;
				if (cnt_q == 4'd0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				min_q[i] <= MIN_RESET;
				max_q[i] <= '0;
			end
		end else if (upd_cal) begin
			if (s_w > hi) begin
				max_q[idx] <= s_w;
			end
			if (s_w < lo) begin
				min_q[idx] <= s_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_entry) begin
			e_q <= q_data;
		end
		if (ld_uncal) begin
			uncal_q <= 1'b1;
			clip_q  <= 1'b0;
			quo_q   <= '0;
		end else if (ld_div) begin
			uncal_q <= 1'b0;
			clip_q  <= clip_d;
			rem_q   <= {ten_d, 8'b0};
			dsh_q   <= {1'b0, span, 11'b0};
			quo_q   <= '0;
			cnt_q   <= 4'(QUO_BITS - 1);
		end else if (step) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_slot_q  <= e_q.slot;
			out_level_q <= level_d;
			out_clip_q  <= clip_q;
			out_uncal_q <= uncal_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_level_q, out_slot_q};
	assign m_tuser  = {out_uncal_q, out_clip_q};

endmodule

// ===== hdl/sensor_minmax_calibrate_normalize.sv =====
// Top level of the six-slot sensor min/max calibrate and normalize block.
// Samples enter on the s_ stream; cmd in s_tuser picks calibrate or normalize, and
// channels without a slot are taken and dropped. The front end accepts one sample
// per cycle while its two-entry queue has room. The back end takes a calibrate item
// through fetch and min/max update, and a normalize item through fetch, min/max load,
// 12 steps of the restoring divider and result load; it takes no new item until the
// last one is done, so the divider sets the sustained rate. An uncalibrated slot
// skips the divider. A finished level waits in the m_ output register while the
// back end moves on. The invert register is written by cfg_wen.
`include "sensor_minmax_calibrate_normalize_defines.svh"
module sensor_minmax_calibrate_normalize #(
	parameter int NUM_SLOTS = 6,
	parameter int SAMPLE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,   // invert
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // adc_channel[2:0], sample[14:3], zero[15]
	input  logic        s_tuser,     // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // slot[2:0], level[14:3], zero[15]
	output logic [1:0]  m_tuser      // clipped[0], uncalibrated[1]
);
	import smcn_pkg::*;

	logic   invert_q;
	logic   fq_valid;
	logic   fq_ready;
	entry_t fq_data;
	logic   qb_valid;
	logic   qb_ready;
	entry_t qb_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg_wen) begin
			invert_q <= cfg_wdata;
		end
	end

	smcn_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	smcn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_valid),
		.in_ready (fq_ready),
		.in_data  (fq_data),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_data (qb_data)
	);

	smcn_back #(
		.NUM_SLOTS  (NUM_SLOTS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.invert  (invert_q),
		.q_valid (qb_valid),
		.q_ready (qb_ready),
		.q_data  (qb_data),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	`SMCN_ASSERT_IMPL(a_level_range, m_tvalid, m_tdata[14:3] <= FULL_SCALE, "level above full scale")
	`SMCN_ASSERT_IMPL(a_uncal_zero, m_tvalid && m_tuser[1], m_tdata[14:3] == '0 && !m_tuser[0], "uncal not zero")
	`SMCN_ASSERT_IMPL(a_slot_range, m_tvalid, {1'b0, m_tdata[2:0]} < 4'(NUM_SLOTS), "result slot out of range")
	`SMCN_ASSERT_NEXT(a_unmapped_drop, s_tvalid && s_tready && !fq_valid, !$rose(qb_valid), "unmapped sample queued")

endmodule

// ===== sim/tb.sv =====
// Testbench for the six-slot sensor min/max calibrate and normalize block.
`timescale 1ns / 1ps
module tb;
	import smcn_pkg::*;

	localparam int NUM_SLOTS = 6;
	localparam int SETTLE_CYCLES = 64;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS = 10;
	localparam logic [31:0] CHAN_SLOTS = {4'd1, 4'd0, 4'd5, 4'd3, 4'd2, NO_SLOT, NO_SLOT, 4'd4};

	typedef struct packed {
		logic [2:0]  slot;
		logic [11:0] level;
		logic        clipped;
		logic        uncal;
	} level_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	level_result_t expected_levels [$];
	logic [11:0]   cal_min [NUM_SLOTS];
	logic [11:0]   cal_max [NUM_SLOTS];
	logic          invert_on = 1'b0;
	int            band_lo [NUM_SLOTS] = '{0, 1000, 200, 2048, 3000, 2000};
	int            band_hi [NUM_SLOTS] = '{4095, 1400, 3900, 2100, 4000, 2000};
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            mismatches = 0;
	int            cycles = 0;

	sensor_minmax_calibrate_normalize u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("FAIL sensor_minmax_calibrate_normalize");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		level_result_t got;
		level_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[2:0], m_tdata[14:3], m_tuser[0], m_tuser[1]};
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: slot %0d level %0d clipped %0b uncal %0b",
						got.slot, got.level, got.clipped, got.uncal);
			end else begin
				want = expected_levels.pop_front();
				if (got.slot !== want.slot || got.level !== want.level ||
						got.clipped !== want.clipped || got.uncal !== want.uncal) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: slot %0d/%0d level %0d/%0d clipped %0b/%0b uncal %0b/%0b (exp/got)",
							want.slot, got.slot, want.level, got.level,
							want.clipped, got.clipped, want.uncal, got.uncal);
				end
			end
		end
	end

	// Update the calibration state and queue the level a normalize transaction yields.
	task automatic predict_level(input logic cmd, input logic [2:0] chan, input logic [11:0] sample);
		logic [3:0]    slot;
		int unsigned   lo;
		int unsigned   hi;
		int unsigned   s;
		int unsigned   lvl;
		level_result_t r;
		slot = CHAN_SLOTS[chan*4 +: 4];
		if (slot >= NUM_SLOTS)
			return;
		lo = cal_min[slot];
		hi = cal_max[slot];
		s = sample;
		if (cmd == CMD_CALIBRATE) begin
			if (s > hi)
				cal_max[slot] = sample;
			if (s < lo)
				cal_min[slot] = sample;
			return;
		end
		r.slot = slot[2:0];
		r.clipped = 1'b0;
		r.uncal = 1'b0;
		lvl = 0;
		if (hi <= lo) begin
			r.uncal = 1'b1;
		end else begin
			if (s < lo) begin
				s = lo;
				r.clipped = 1'b1;
			end else if (s > hi) begin
				s = hi;
				r.clipped = 1'b1;
			end
			lvl = ((s - lo) * 32'(FULL_SCALE)) / (hi - lo);
			if (invert_on)
				lvl = 32'(FULL_SCALE) - lvl;
		end
		r.level = lvl[11:0];
		expected_levels.push_back(r);
	endtask

	task automatic send_item(input logic cmd, input logic [2:0] chan, input logic [11:0] sample);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, sample, chan};
		s_tuser <= cmd;
		do
			@(posedge clk);
		while (!s_tready);
		predict_level(cmd, chan, sample);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_invert(input logic value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		invert_on = value;
	endtask

	task automatic test_uncalibrated();
		send_item(CMD_NORMALIZE, 3'd6, 12'd0);
		send_item(CMD_NORMALIZE, 3'd7, 12'd4095);
		send_item(CMD_NORMALIZE, 3'd3, 12'd2048);
		send_item(CMD_NORMALIZE, 3'd4, 12'd1);
		send_item(CMD_NORMALIZE, 3'd0, 12'd4094);
		send_item(CMD_NORMALIZE, 3'd5, 12'd2730);
		send_item(CMD_NORMALIZE, 3'd1, 12'd4095);
		send_item(CMD_CALIBRATE, 3'd2, 12'd4095);
	endtask

	task automatic test_calibrate_normalize();
		send_item(CMD_CALIBRATE, 3'd6, 12'd0);
		send_item(CMD_CALIBRATE, 3'd6, 12'd4095);
		send_item(CMD_NORMALIZE, 3'd6, 12'd0);
		send_item(CMD_NORMALIZE, 3'd6, 12'd4095);
		send_item(CMD_NORMALIZE, 3'd6, 12'd2048);
		send_item(CMD_CALIBRATE, 3'd5, 12'd2000);
		send_item(CMD_NORMALIZE, 3'd5, 12'd2000);
		send_item(CMD_CALIBRATE, 3'd7, 12'd1000);
		send_item(CMD_CALIBRATE, 3'd7, 12'd1400);
		send_item(CMD_NORMALIZE, 3'd7, 12'd999);
		send_item(CMD_NORMALIZE, 3'd7, 12'd1401);
		send_item(CMD_NORMALIZE, 3'd7, 12'd1200);
		send_item(CMD_CALIBRATE, 3'd3, 12'd200);
		send_item(CMD_CALIBRATE, 3'd3, 12'd3900);
		send_item(CMD_CALIBRATE, 3'd4, 12'd2048);
		send_item(CMD_CALIBRATE, 3'd4, 12'd2100);
		send_item(CMD_CALIBRATE, 3'd0, 12'd3000);
		send_item(CMD_CALIBRATE, 3'd0, 12'd4000);
		send_item(CMD_NORMALIZE, 3'd3, 12'd3333);
		send_item(CMD_NORMALIZE, 3'd4, 12'd2099);
		send_item(CMD_NORMALIZE, 3'd0, 12'd3001);
	endtask

	task automatic test_inverted();
		wait_idle();
		write_invert(1'b1);
		send_item(CMD_NORMALIZE, 3'd6, 12'd0);
		send_item(CMD_NORMALIZE, 3'd6, 12'd4095);
		send_item(CMD_NORMALIZE, 3'd5, 12'd2000);
		send_item(CMD_NORMALIZE, 3'd7, 12'd999);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int items,
			input logic inv, input bit hold_midway);
		int          count;
		logic [2:0]  chan;
		logic [3:0]  slot;
		logic        cmd;
		int          lo;
		int          hi;
		logic [11:0] sample;
		wait_idle();
		write_invert(inv);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		count = 0;
		while (count < items) begin
			chan = 3'($urandom_range(0, 7));
			slot = CHAN_SLOTS[chan*4 +: 4];
			if (slot >= NUM_SLOTS) begin
				send_item(1'($urandom), chan, 12'($urandom));
				continue;
			end
			cmd = ($urandom_range(0, 9) < 3) ? CMD_CALIBRATE : CMD_NORMALIZE;
			lo = band_lo[slot] - 20;
			hi = band_hi[slot] + 20;
			if (lo < 0)
				lo = 0;
			if (hi > 4095)
				hi = 4095;
			if (cmd == CMD_CALIBRATE)
				sample = 12'($urandom_range(band_lo[slot], band_hi[slot]));
			else if ($urandom_range(0, 1))
				sample = 12'($urandom_range(lo, hi));
			else
				sample = 12'($urandom);
			send_item(cmd, chan, sample);
			count++;
			if (hold_midway && count == items / 2)
				wait_idle();
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			cal_min[i] = 12'd4095;
			cal_max[i] = 12'd0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_uncalibrated();
		test_calibrate_normalize();
		test_inverted();
		test_random_traffic(0, 0, 270, 1'b0, 1'b0);
		test_random_traffic(58, 0, 270, 1'b1, 1'b1);
		test_random_traffic(0, 58, 270, 1'b0, 1'b0);
		test_random_traffic(14, 14, 270, 1'b1, 1'b0);
		wait_idle();
		if (mismatches == 0 && expected_levels.size() == 0)
			$display("PASS sensor_minmax_calibrate_normalize");
		else
			$display("FAIL sensor_minmax_calibrate_normalize");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/smcn_pkg.sv
hdl/smcn_front.sv
hdl/smcn_queue.sv
hdl/smcn_back.sv
hdl/sensor_minmax_calibrate_normalize.sv
sim/tb.sv
